// File: rtl/cdq_pkg.sv
// Shared types, constants and operation codes for the circular deque.
package cdq_pkg;

  localparam int CDQ_DEPTH = 16;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int LIMIT_W   = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INS_REAR  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL_FRONT = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DEL_REAR  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_NOP       = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } cdq_state_t;

  typedef struct packed {
    logic exec;
    logic load;
  } cdq_cmd_t;

endpackage

// File: rtl/cdq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/cdq_ctrl.sv
// Controller state machine: accept, read, result capture and output valid.
module cdq_ctrl import cdq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output cdq_cmd_t cmd
);

  cdq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTH
  a_read_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_DONE)
    else $error("read state not followed by capture");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result valid without capture");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_tready))
    else $error("result overwritten before taken");
`endif

endmodule

// File: rtl/cdq_dp.sv
// Datapath: pointers, occupancy, size limit, store and result registers.
module cdq_dp import cdq_pkg::*; #(
  parameter int DEPTH = CDQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cdq_cmd_t           cmd,
  input  logic [FUNC_W-1:0]  func,
  input  logic [DATA_W-1:0]  value,
  input  logic               cfg_wen,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output logic [DATA_W-1:0]  front_value,
  output logic [DATA_W-1:0]  rear_value,
  output logic               ok,
  output logic               empty_res,
  output logic               full_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int LW = (OW > LIMIT_W) ? OW : LIMIT_W;

  logic [AW-1:0]      head_r, head_nxt, tail_r, tail_nxt;
  logic [AW-1:0]      head_prev, head_next, tail_prev, tail_next;
  logic [OW-1:0]      occ_r, occ_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic               ok_r, ok_nxt;
  logic               ok_pend_r;
  logic [LW-1:0]      limit_w, eff_limit;
  logic               full, empty;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [DATA_W-1:0]  rdata_a, rdata_b;
  logic [DATA_W-1:0]  front_r, rear_r;
  logic               empty_r, full_r;

  assign limit_w   = LW'(limit_r);
  assign eff_limit = (limit_w > LW'(DEPTH)) ? LW'(DEPTH) : limit_w;
  assign full      = LW'(occ_r) >= eff_limit;
  assign empty     = occ_r == '0;

  assign head_prev = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign head_next = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_prev = (tail_r == '0) ? AW'(DEPTH - 1) : tail_r - 1'b1;
  assign tail_next = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    ok_nxt   = 1'b0;
    we       = 1'b0;
    waddr    = tail_r;
    case (func)
      FUNC_INS_FRONT: begin
        if (!full) begin
          head_nxt = head_prev;
          waddr    = head_prev;
          we       = cmd.exec;
          occ_nxt  = occ_r + 1'b1;
          ok_nxt   = 1'b1;
        end
      end
      FUNC_INS_REAR: begin
        if (!full) begin
          tail_nxt = tail_next;
          waddr    = tail_r;
          we       = cmd.exec;
          occ_nxt  = occ_r + 1'b1;
          ok_nxt   = 1'b1;
        end
      end
      FUNC_DEL_FRONT: begin
        if (!empty) begin
          head_nxt = head_next;
          occ_nxt  = occ_r - 1'b1;
          ok_nxt   = 1'b1;
        end
      end
      FUNC_DEL_REAR: begin
        if (!empty) begin
          tail_nxt = tail_prev;
          occ_nxt  = occ_r - 1'b1;
          ok_nxt   = 1'b1;
        end
      end
      FUNC_NOP: begin
        ok_nxt = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
      limit_r <= LIMIT_RESET;
    end else begin
      if (cmd.exec) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        occ_r  <= occ_nxt;
      end
      if (cfg_wen) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // ok is held aside until capture so a waiting result keeps its own flag
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_pend_r <= ok_nxt;
    end
    if (cmd.load) begin
      ok_r    <= ok_pend_r;
      front_r <= empty ? '1 : rdata_a;
      rear_r  <= empty ? '1 : rdata_b;
      empty_r <= empty;
      full_r  <= full;
    end
  end

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (value),
    .raddr_a (head_r),
    .rdata_a (rdata_a),
    .raddr_b (tail_prev),
    .rdata_b (rdata_b)
  );

  assign front_value = front_r;
  assign rear_value  = rear_r;
  assign ok          = ok_r;
  assign empty_res   = empty_r;
  assign full_res    = full_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= DEPTH)
    else $error("occupancy above depth");

  a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
    int'(tail_r) == (int'(head_r) + int'(occ_r)) % DEPTH)
    else $error("head, tail and occupancy disagree");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && we |=> int'(occ_r) == int'($past(occ_r)) + 1)
    else $error("insert did not raise occupancy");
`endif

endmodule

// File: rtl/circular_deque.sv
// Top level of the circular deque: stream ports, controller and datapath.
//
// A double-ended queue of up to DEPTH 32-bit values. Each input item carries
// an operation in in_tuser (insert front, insert rear, delete front, delete
// rear, no change) and a value in in_tdata; each produces one result with the
// success flag, the front and rear entries after the operation (all ones when
// empty) and the empty and full flags. An item passes from acceptance through
// execute and write, store read (set by the registered read ports of the store)
// and capture. A new item is accepted once the previous one is captured, even
// while that result still waits on the output. The user writes size_limit through
// cfg_wen/cfg_wdata only while the deque is empty; the block does not enforce
// this. The effective limit is the smaller of size_limit and DEPTH. The store
// needs no clearing after reset.
module circular_deque import cdq_pkg::*; #(
  parameter int DEPTH = CDQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,   // value
  input  logic [FUNC_W-1:0]  in_tuser,   // func
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata,  // front_value, rear_value
  output logic [2:0]         out_tuser,  // ok, empty_res, full_res
  input  logic               cfg_wen,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  cdq_cmd_t          cmd;
  logic [DATA_W-1:0] front_value, rear_value;
  logic              ok, empty_res, full_res;

  cdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .func        (in_tuser),
    .value       (in_tdata),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .front_value (front_value),
    .rear_value  (rear_value),
    .ok          (ok),
    .empty_res   (empty_res),
    .full_res    (full_res)
  );

  assign out_tdata = {rear_value, front_value};
  assign out_tuser = {full_res, empty_res, ok};

endmodule

// File: sim/circular_deque_tb.sv
// Self-checking testbench for circular_deque: directed and random deque traffic.
`timescale 1ns / 100ps

module circular_deque_tb;
  import cdq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = FUNC_NOP + 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = {FUNC_W{1'b1}};

  typedef struct {
    logic              ok;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] rear_value;
    logic              empty_res;
    logic              full_res;
  } deque_result_t;

  class deque_checker;
    logic [DATA_W-1:0]  slots [CDQ_DEPTH];
    int                 head;
    int                 tail;
    int                 count;
    logic [LIMIT_W-1:0] size_limit;
    deque_result_t      expected_results [$];
    int                 errors;
    int                 items;
    int                 refused;
    int                 full_seen;
    int                 limit_writes;

    function new();
      head = 0;
      tail = 0;
      count = 0;
      size_limit = LIMIT_RESET;
    endfunction

    function int occupancy_cap();
      return (size_limit > CDQ_DEPTH) ? CDQ_DEPTH : int'(size_limit);
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      size_limit = v;
      limit_writes++;
    endfunction

    // Applies one operation and queues the result it must produce.
    function void note_op(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v);
      deque_result_t r;
      bit is_full;
      bit is_empty;
      is_full = count >= occupancy_cap();
      is_empty = count == 0;
      r.ok = 1'b0;
      case (f)
        FUNC_INS_FRONT: begin
          if (!is_full) begin
            head = (head == 0) ? CDQ_DEPTH - 1 : head - 1;
            slots[head] = v;
            count++;
            r.ok = 1'b1;
          end
        end
        FUNC_INS_REAR: begin
          if (!is_full) begin
            slots[tail] = v;
            tail = (tail == CDQ_DEPTH - 1) ? 0 : tail + 1;
            count++;
            r.ok = 1'b1;
          end
        end
        FUNC_DEL_FRONT: begin
          if (!is_empty) begin
            head = (head == CDQ_DEPTH - 1) ? 0 : head + 1;
            count--;
            r.ok = 1'b1;
          end
        end
        FUNC_DEL_REAR: begin
          if (!is_empty) begin
            tail = (tail == 0) ? CDQ_DEPTH - 1 : tail - 1;
            count--;
            r.ok = 1'b1;
          end
        end
        FUNC_NOP: r.ok = 1'b1;
        default: r.ok = 1'b0;
      endcase
      r.empty_res = count == 0;
      r.full_res = count >= occupancy_cap();
      if (r.empty_res) begin
        r.front_value = '1;
        r.rear_value = '1;
      end else begin
        r.front_value = slots[head];
        r.rear_value = slots[(tail == 0) ? CDQ_DEPTH - 1 : tail - 1];
      end
      items++;
      if (!r.ok) refused++;
      if (r.full_res) full_seen++;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [63:0] data, logic [2:0] flags);
      deque_result_t e;
      if (expected_results.size() == 0) begin
        $error("result with no item pending: tdata %h tuser %b", data, flags);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (flags[0] !== e.ok) begin
        $error("ok: expected %0d, got %0d", e.ok, flags[0]);
        errors++;
      end
      if (data[31:0] !== e.front_value) begin
        $error("front_value: expected %0d, got %0d", $signed(e.front_value),
               $signed(data[31:0]));
        errors++;
      end
      if (data[63:32] !== e.rear_value) begin
        $error("rear_value: expected %0d, got %0d", $signed(e.rear_value),
               $signed(data[63:32]));
        errors++;
      end
      if (flags[1] !== e.empty_res) begin
        $error("empty_res: expected %0d, got %0d", e.empty_res, flags[1]);
        errors++;
      end
      if (flags[2] !== e.full_res) begin
        $error("full_res: expected %0d, got %0d", e.full_res, flags[2]);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [31:0]        in_tdata;   // value
  logic [FUNC_W-1:0]  in_tuser;   // func
  logic               out_tvalid;
  logic               out_tready;
  logic [63:0]        out_tdata;  // front_value, rear_value
  logic [2:0]         out_tuser;  // ok, empty_res, full_res
  logic               cfg_wen;
  logic [LIMIT_W-1:0] cfg_wdata;

  int in_idle_pct;
  int out_stall_pct;

  deque_checker sb = new();

  circular_deque i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_op(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // in_tvalid stays high after acceptance so back-to-back items need no toggle.
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [31:0] v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.set_limit(v);
  endtask

  // Bursts lean toward inserts or deletes in turn so full and empty both occur.
  task automatic random_ops(input int n);
    int insert_pct;
    int burst;
    logic [FUNC_W-1:0] f;
    logic [31:0] v;
    insert_pct = 25;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(24, 4);
        insert_pct = (insert_pct > 50) ? 25 : 75;
      end
      burst--;
      if ($urandom_range(99) < 6)
        f = FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_NOP));
      else if ($urandom_range(99) < insert_pct)
        f = ($urandom_range(1) != 0) ? FUNC_INS_REAR : FUNC_INS_FRONT;
      else
        f = ($urandom_range(1) != 0) ? FUNC_DEL_REAR : FUNC_DEL_FRONT;
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end else begin
        v = $urandom;
      end
      send_op(f, v);
    end
  endtask

  task automatic drain();
    int n;
    n = sb.count;
    for (int i = 0; i < n; i++)
      send_op((i % 2 != 0) ? FUNC_DEL_REAR : FUNC_DEL_FRONT, $urandom);
  endtask

  initial begin
    logic [LIMIT_W-1:0] limits [8];
    limits = '{5'd16, 5'd31, 5'd1, 5'd4, 5'd2, 5'd17, 5'd9, 5'd3};
    in_idle_pct = 0;
    out_stall_pct = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= FUNC_NOP;
    out_tready <= 1'b0;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // refusals on empty and unused codes, and a no-change operation
    send_op(FUNC_DEL_FRONT, 32'h1234_5678);
    send_op(FUNC_DEL_REAR, 32'h0);
    send_op(FUNC_NOP, 32'hFFFF_FFFF);
    send_op(FUNC_UNUSED_LO, 32'h1);
    send_op(FUNC_UNUSED_LO + 3'd1, 32'h2);
    send_op(FUNC_UNUSED_HI, 32'h3);
    // value extremes at both ends
    send_op(FUNC_INS_FRONT, 32'h7FFF_FFFF);
    send_op(FUNC_INS_REAR, 32'h8000_0000);
    send_op(FUNC_INS_FRONT, 32'h0000_0000);
    send_op(FUNC_INS_REAR, 32'hFFFF_FFFF);
    send_op(FUNC_DEL_FRONT, 32'h0);
    send_op(FUNC_DEL_REAR, 32'h0);
    // limit dropped below occupancy
    wait_idle();
    write_limit(5'd1);
    send_op(FUNC_INS_REAR, 32'h1);
    send_op(FUNC_DEL_FRONT, 32'h0);
    send_op(FUNC_INS_FRONT, 32'h2);
    send_op(FUNC_DEL_REAR, 32'h0);
    // zero limit: empty and full together
    wait_idle();
    write_limit(5'd0);
    send_op(FUNC_INS_FRONT, 32'h3);
    send_op(FUNC_NOP, 32'h0);
    wait_idle();
    write_limit(5'd2);
    send_op(FUNC_INS_REAR, 32'h5A5A_5A5A);
    send_op(FUNC_INS_FRONT, 32'hA5A5_A5A5);
    send_op(FUNC_INS_REAR, 32'h4);
    send_op(FUNC_DEL_REAR, 32'h0);
    send_op(FUNC_DEL_FRONT, 32'h0);
    send_op(FUNC_DEL_FRONT, 32'h0);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_limit(limits[p]);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 57; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 57; end
        default: begin in_idle_pct = 37; out_stall_pct = 37; end
      endcase
      random_ops(75);
      wait_idle();
      drain();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d items over %0d size-limit writes (0 to 31), %0d refused,",
             sb.items, sb.limit_writes, sb.refused);
    $display("%0d results reporting full, under four handshake pacing modes", sb.full_seen);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
